// ----- hdl/lu2u_pkg.sv -----
package lu2u_pkg;

  // Parser position within the byte stream
  typedef enum logic [1:0] {
    PH_LEN_HI  = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_UNIT_HI = 2'd2,
    PH_UNIT_LO = 2'd3
  } lu2u_phase_t;

  // One queued job: up to three results pushed on one accepted input byte.
  // A bare marker is cnt_m1 = 0 with data = 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            data;
    logic            last;
    logic            status;
  } lu2u_op_t;

  localparam logic [15:0] LU2U_MAX_LENGTH_RST = 16'd32767;
  localparam logic [12:0] LU2U_CAPACITY_RST   = 13'd1024;
  localparam logic [12:0] LU2U_HEADROOM       = 13'd4;

  localparam logic [15:0] LU2U_ONE_BYTE_LIM = 16'h0080;
  localparam logic [15:0] LU2U_TWO_BYTE_LIM = 16'h0800;
  localparam logic [7:0]  LU2U_LEAD2        = 8'hC0;
  localparam logic [7:0]  LU2U_LEAD3        = 8'hE0;
  localparam logic [7:0]  LU2U_CONT         = 8'h80;

  localparam logic       LU2U_ST_OK          = 1'b0;
  localparam logic       LU2U_ST_TOO_LONG    = 1'b1;

  // Register map (byte address bit 2 selects the register)
  localparam logic LU2U_REG_MAX_LENGTH = 1'b0;
  localparam logic LU2U_REG_CAPACITY   = 1'b1;

endpackage

// ----- hdl/lu2u_front.sv -----
module lu2u_front
  import lu2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  input  logic [15:0] max_length,
  input  logic [12:0] output_capacity,
  output logic        in_stall,
  output logic        push,
  output lu2u_op_t    push_op
);

  lu2u_phase_t phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] units_r, units_nxt;
  logic [7:0]  unit_hi_r, unit_hi_nxt;
  logic [12:0] written_r, written_nxt;
  logic        stopped_r, stopped_nxt;

  logic        acc;
  logic [15:0] full_len;
  logic [15:0] code;
  logic        closing;
  logic        at_cap;
  logic [1:0]  cnt;
  logic [2:0][7:0] enc;

  assign in_stall = q_full;
  assign acc      = in_valid & ~q_full;
  assign full_len = {len_hi_r, in_data_byte};
  assign code     = {unit_hi_r, in_data_byte};
  assign closing  = (units_r == 16'd1);
  assign at_cap   = ({1'b0, written_r} + {1'b0, LU2U_HEADROOM}) >= {1'b0, output_capacity};

  // UTF-8 encode of the current unit
  always_comb begin
    enc = '0;
    cnt = 2'd0;
    if (!stopped_r && !at_cap && code != 16'd0) begin
      if (code < LU2U_ONE_BYTE_LIM) begin
        enc[0] = code[7:0];
        cnt    = 2'd1;
      end else if (code < LU2U_TWO_BYTE_LIM) begin
        enc[0] = LU2U_LEAD2 | {3'b000, code[10:6]};
        enc[1] = LU2U_CONT | {2'b00, code[5:0]};
        cnt    = 2'd2;
      end else begin
        enc[0] = LU2U_LEAD3 | {4'h0, code[15:12]};
        enc[1] = LU2U_CONT | {2'b00, code[11:6]};
        enc[2] = LU2U_CONT | {2'b00, code[5:0]};
        cnt    = 2'd3;
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_LEN_HI:  phase_nxt = PH_LEN_LO;
        PH_LEN_LO:  phase_nxt = (full_len > max_length || full_len == 16'd0) ?
                                PH_LEN_HI : PH_UNIT_HI;
        PH_UNIT_HI: phase_nxt = PH_UNIT_LO;
        PH_UNIT_LO: phase_nxt = closing ? PH_LEN_HI : PH_UNIT_HI;
        default:    phase_nxt = PH_LEN_HI;
      endcase
    end
  end

  // Datapath and queue write
  always_comb begin
    len_hi_nxt  = len_hi_r;
    units_nxt   = units_r;
    unit_hi_nxt = unit_hi_r;
    written_nxt = written_r;
    stopped_nxt = stopped_r;
    push        = 1'b0;
    push_op     = '0;
    if (acc) begin
      unique case (phase_r)
        PH_LEN_HI: len_hi_nxt = in_data_byte;
        PH_LEN_LO: begin
          if (full_len > max_length) begin
            push           = 1'b1;
            push_op.last   = 1'b1;
            push_op.status = LU2U_ST_TOO_LONG;
          end else if (full_len == 16'd0) begin
            push           = 1'b1;
            push_op.last   = 1'b1;
            push_op.status = LU2U_ST_OK;
          end else begin
            units_nxt   = full_len;
            written_nxt = '0;
            stopped_nxt = 1'b0;
          end
        end
        PH_UNIT_HI: unit_hi_nxt = in_data_byte;
        PH_UNIT_LO: begin
          units_nxt   = units_r - 16'd1;
          written_nxt = written_r + {11'd0, cnt};
          if (!stopped_r && (at_cap || code == 16'd0)) stopped_nxt = 1'b1;
          if (cnt != 2'd0) begin
            push           = 1'b1;
            push_op.bytes  = enc;
            push_op.cnt_m1 = cnt - 2'd1;
            push_op.data   = 1'b1;
            push_op.last   = closing;
          end else if (closing) begin
            push           = 1'b1;
            push_op.last   = 1'b1;
            push_op.status = LU2U_ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_HI;
      len_hi_r  <= '0;
      units_r   <= '0;
      unit_hi_r <= '0;
      written_r <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      len_hi_r  <= len_hi_nxt;
      units_r   <= units_nxt;
      unit_hi_r <= unit_hi_nxt;
      written_r <= written_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ----- hdl/lu2u_fifo.sv -----
module lu2u_fifo
  import lu2u_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lu2u_op_t push_op,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output lu2u_op_t head_op
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lu2u_op_t      mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign head_op = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/lu2u_back.sv -----
module lu2u_back
  import lu2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  lu2u_op_t   head_op,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_status
);

  lu2u_op_t   op_r, op_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       obv_r, obv_nxt, ol_r, ol_nxt, os_r, os_nxt;

  logic out_free, emit, op_done;

  assign out_free = ~ov_r | ~out_stall;
  assign emit     = busy_r & out_free;
  assign op_done  = emit & (idx_r == op_r.cnt_m1);
  assign pop      = ~q_empty & (~busy_r | op_done);

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r & out_stall;
    ob_nxt   = ob_r;
    obv_nxt  = obv_r;
    ol_nxt   = ol_r;
    os_nxt   = os_r;
    if (emit) begin
      ov_nxt  = 1'b1;
      ob_nxt  = op_r.data ? op_r.bytes[idx_r] : 8'h00;
      obv_nxt = op_r.data;
      ol_nxt  = op_r.last & (idx_r == op_r.cnt_m1);
      os_nxt  = op_r.status;
      idx_nxt = idx_r + 2'd1;
    end
    if (op_done) busy_nxt = 1'b0;
    if (pop) begin
      op_nxt   = head_op;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ob_r  <= ob_nxt;
    obv_r <= obv_nxt;
    ol_r  <= ol_nxt;
    os_r  <= os_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_last       = ol_r;
  assign out_status     = os_r;

endmodule

// ----- hdl/length_prefixed_utf16be_to_utf8.sv -----
// Path: the job queue, then the back end's job register, then the output register.
// Throughput: one input byte per cycle while the job queue has room; the back
// end drains one result per cycle while out_stall is low, so a unit (2 bytes in)
// giving 3 bytes out is paced by the single output port once the queue fills.
// Reset (rst_n, synchronous): parser back to length high byte, queue and
// output empty, max_length = 32767, output_capacity = 1024.
module length_prefixed_utf16be_to_utf8
  import lu2u_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // UTF-8 results out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic        out_status,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Config registers: bit 2 of the address picks the register
  logic [15:0] max_length_r;
  logic [12:0] capacity_r;
  logic        wr_req;

  assign pready = 1'b1;
  assign wr_req = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= LU2U_MAX_LENGTH_RST;
      capacity_r   <= LU2U_CAPACITY_RST;
    end else if (wr_req) begin
      unique case (paddr[2])
        LU2U_REG_MAX_LENGTH: max_length_r <= pwdata[15:0];
        LU2U_REG_CAPACITY:   capacity_r   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      LU2U_REG_MAX_LENGTH: prdata = {16'd0, max_length_r};
      LU2U_REG_CAPACITY:   prdata = {19'd0, capacity_r};
      default:             prdata = '0;
    endcase
  end

  // Front: parses length/unit bytes and encodes each request into a job
  logic     q_full, q_empty, q_push, q_pop;
  lu2u_op_t push_op, head_op;

  lu2u_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_data_byte    (in_data_byte),
    .q_full          (q_full),
    .max_length      (max_length_r),
    .output_capacity (capacity_r),
    .in_stall        (in_stall),
    .push            (q_push),
    .push_op         (push_op)
  );

  // Job queue decouples parsing from result delivery
  lu2u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head_op (head_op)
  );

  // Back: unrolls each job into the output register, one result per cycle unless stalled
  lu2u_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head_op        (head_op),
    .pop            (q_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Bench for the length-prefixed UTF-16BE to UTF-8 converter.
// Requests go in one raw stream byte at a time. A parser model inside the bench
// predicts the UTF-8 bytes and markers for every accepted request. The checker
// pops and compares each result as it leaves the block. Both channels idle at
// random. Register settings change only while nothing is in flight.
module tb;
  import lu2u_pkg::*;

  // one predicted result, field for field as it leaves the block
  typedef struct packed {
    logic [7:0] byt;
    logic       bv;
    logic       last;
    logic       status;
  } utf8_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last;
  logic        out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  length_prefixed_utf16be_to_utf8 uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // register mirror, reset values as the block comes out of reset
  logic [15:0] cfg_max_len = LU2U_MAX_LENGTH_RST;
  logic [12:0] cfg_cap     = LU2U_CAPACITY_RST;

  // parser model state
  lu2u_phase_t prs_phase  = PH_LEN_HI;
  logic [15:0] fld_len    = 16'd0;
  logic [15:0] units_left = 16'd0;
  logic [7:0]  unit_hi    = 8'd0;
  logic [12:0] written    = 13'd0;
  logic        stopped    = 1'b0;

  utf8_result_t utf8_pending[$];
  int fault_count  = 0;
  int stream_bytes = 0;
  int stall_left   = 0;
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // append one expectation at the tail of the queue
  function automatic void push_utf8(input logic [7:0] byt, input logic bv,
                                    input logic last, input logic status);
    utf8_result_t item;
    item.byt    = byt;
    item.bv     = bv;
    item.last   = last;
    item.status = status;
    utf8_pending.insert(utf8_pending.size(), item);
  endfunction

  // Parser model: advance on one accepted stream byte and queue whatever
  // results that byte causes.
  function automatic void encode_utf8_byte(input logic [7:0] b);
    logic [15:0] code;
    logic [7:0]  enc [3];
    int          cnt;
    int          i;
    logic        closing;
    cnt = 0;
    case (prs_phase)
      PH_LEN_HI: begin
        fld_len   = {b, 8'h00};
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fld_len[7:0] = b;
        prs_phase    = PH_LEN_HI;
        if (fld_len > cfg_max_len) begin
          push_utf8(8'h00, 1'b0, 1'b1, LU2U_ST_TOO_LONG);
        end else if (fld_len == 16'd0) begin
          push_utf8(8'h00, 1'b0, 1'b1, LU2U_ST_OK);
        end else begin
          units_left = fld_len;
          written    = 13'd0;
          stopped    = 1'b0;
          prs_phase  = PH_UNIT_HI;
        end
      end
      PH_UNIT_HI: begin
        unit_hi   = b;
        prs_phase = PH_UNIT_LO;
      end
      default: begin
        code       = {unit_hi, b};
        units_left = units_left - 16'd1;
        closing    = (units_left == 16'd0);
        if (!stopped) begin
          // headroom for a full 3-byte sequence plus the terminator
          if (int'(written) + int'(LU2U_HEADROOM) >= int'(cfg_cap) || code == 16'd0) begin
            stopped = 1'b1;
          end else if (code < LU2U_ONE_BYTE_LIM) begin
            enc[0] = code[7:0];
            cnt    = 1;
          end else if (code < LU2U_TWO_BYTE_LIM) begin
            enc[0] = LU2U_LEAD2 | {3'b000, code[10:6]};
            enc[1] = LU2U_CONT | {2'b00, code[5:0]};
            cnt    = 2;
          end else begin
            // surrogates land here too, each one encoded on its own
            enc[0] = LU2U_LEAD3 | {4'h0, code[15:12]};
            enc[1] = LU2U_CONT | {2'b00, code[11:6]};
            enc[2] = LU2U_CONT | {2'b00, code[5:0]};
            cnt    = 3;
          end
        end
        for (i = 0; i < cnt; i++)
          push_utf8(enc[i], 1'b1, closing && (i == cnt - 1), LU2U_ST_OK);
        written = written + 13'(cnt);
        if (closing) begin
          // closing unit emitted nothing: bare end marker
          if (cnt == 0) push_utf8(8'h00, 1'b0, 1'b1, LU2U_ST_OK);
          prs_phase = PH_LEN_HI;
        end else begin
          prs_phase = PH_UNIT_HI;
        end
      end
    endcase
  endfunction

  // Send one request. Valid stays high after acceptance so that back-to-back
  // requests never drop it; any task that waits on other things lowers it first.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? idle_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data_byte = b;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_utf8_byte(b);
    stream_bytes++;
  endtask

  // big-endian 16-bit word: a count or a code unit
  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // Let every expected result drain, then allow for a request still in the
  // pipe that produces nothing, with margin.
  task automatic wait_utf8_drain();
    int cycles;
    @(negedge clk);
    in_valid = 1'b0;
    cycles   = 0;
    while (utf8_pending.size() != 0 && cycles < 4000) begin
      @(posedge clk);
      cycles++;
    end
    if (utf8_pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next expected byte %02h",
               $time, utf8_pending.size(), utf8_pending[0].byt);
      fault_count++;
      utf8_pending.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_read(input logic reg_sel, output logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {reg_sel, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // read a register back and hold it against the mirror
  task automatic check_reg(input logic reg_sel);
    logic [31:0] data;
    logic [15:0] want;
    logic [15:0] got;
    cfg_read(reg_sel, data);
    if (reg_sel == LU2U_REG_MAX_LENGTH) begin
      want = cfg_max_len;
      got  = data[15:0];
    end else begin
      want = {3'b000, cfg_cap};
      got  = {3'b000, data[12:0]};
    end
    if (got !== want) begin
      $display("%0t: register %0d readback, expected %0d, actual %0d",
               $time, reg_sel, want, got);
      fault_count++;
    end
  endtask

  // block must be idle here: callers drain first
  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    psel     = 1'b1;
    penable  = 1'b0;
    pwrite   = 1'b1;
    paddr    = {reg_sel, 2'b00};
    pwdata   = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == LU2U_REG_MAX_LENGTH) cfg_max_len = value[15:0];
    else cfg_cap = value[12:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_reg(reg_sel);
  endtask

  // Result side: random stall pattern, driven at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (rx_idle_on) stall_left = idle_gap();
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  utf8_result_t want_res;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (utf8_pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %02h valid %0b last %0b status %0b",
                 $time, out_byte, out_byte_valid, out_last, out_status);
        fault_count++;
      end else begin
        want_res = utf8_pending.pop_front();
        if (out_byte !== want_res.byt || out_byte_valid !== want_res.bv ||
            out_last !== want_res.last || out_status !== want_res.status) begin
          $display("%0t: mismatch, expected byte %02h valid %0b last %0b status %0b, actual byte %02h valid %0b last %0b status %0b",
                   $time, want_res.byt, want_res.bv, want_res.last, want_res.status,
                   out_byte, out_byte_valid, out_last, out_status);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // registers come out of reset at their documented values
  task automatic test_register_defaults();
    check_reg(LU2U_REG_MAX_LENGTH);
    check_reg(LU2U_REG_CAPACITY);
  endtask

  // empty field, too-long count, every encoding length and its boundaries,
  // a lone surrogate, and a zero unit closing the field
  task automatic test_unit_encodings();
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'd7);
    send_word(16'h007F);
    send_word(16'h0080);
    send_word(16'h07FF);
    send_word(16'h0800);
    send_word(16'hD800);
    send_word(16'hFFFF);
    send_word(16'h0000);
    wait_utf8_drain();
  endtask

  // capacity cut-off, capacity below the headroom, max_length at both ends
  task automatic test_field_limits();
    cfg_write(LU2U_REG_CAPACITY, 32'd5);
    send_word(16'd3);
    send_word(16'h0041);
    send_word(16'h00E9);
    send_word(16'h0043);
    wait_utf8_drain();
    cfg_write(LU2U_REG_CAPACITY, 32'd3);
    send_word(16'd1);
    send_word(16'h0041);
    wait_utf8_drain();
    cfg_write(LU2U_REG_CAPACITY, 32'd4096);
    cfg_write(LU2U_REG_MAX_LENGTH, 32'd0);
    send_word(16'd1);
    send_word(16'd0);
    wait_utf8_drain();
    cfg_write(LU2U_REG_MAX_LENGTH, 32'd65535);
    // zero unit mid-field: the unit after it is swallowed
    send_word(16'd3);
    send_word(16'h20AC);
    send_word(16'h0000);
    send_word(16'h0042);
    wait_utf8_drain();
  endtask

  function automatic logic [15:0] rand_unit();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r <= 5) return 16'($urandom_range(1, 16'h007F));
    if (r <= 9) return 16'($urandom_range(16'h0080, 16'h07FF));
    if (r <= 13) return 16'($urandom_range(16'h0800, 16'hFFFF));
    if (r <= 15) return 16'($urandom_range(16'hD800, 16'hDFFF));
    return 16'($urandom());
  endfunction

  // one field with random content; some empty, some over max_length
  task automatic send_rand_field(input bit pause_mid);
    int          r;
    int          i;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 8)
      len = 16'd0;
    else if (r < 25 && cfg_max_len != 16'hFFFF)
      len = 16'($urandom_range(int'(cfg_max_len) + 1, 65535));
    else
      len = 16'($urandom_range(1, 12));
    send_word(len);
    if (len != 16'd0 && len <= cfg_max_len) begin
      for (i = 0; i < int'(len); i++) begin
        send_word(rand_unit());
        // sender holds off mid-field until the block has drained
        if (pause_mid && i == 0) wait_utf8_drain();
      end
    end
  endtask

  // random stream over several register settings and idle patterns
  task automatic test_random_stream();
    logic [15:0] max_set [6];
    logic [12:0] cap_set [6];
    int          ph;
    int          start;
    int          fields;
    max_set = '{16'hFFFF, 16'd20, 16'd0, 16'd32767, 16'($urandom_range(1, 300)), 16'hFFFF};
    cap_set = '{13'd4096, 13'd5, 13'd1024, 13'd12, 13'($urandom_range(5, 60)), 13'd4096};
    for (ph = 0; ph < 6; ph++) begin
      wait_utf8_drain();
      cfg_write(LU2U_REG_MAX_LENGTH, {16'h0000, max_set[ph]});
      cfg_write(LU2U_REG_CAPACITY, {19'd0, cap_set[ph]});
      // one stretch with no idling on either side, one with only sender gaps
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3) && (ph != 4);
      start  = stream_bytes;
      fields = 0;
      while (stream_bytes - start < 30) begin
        send_rand_field(fields % 7 == 3);
        fields++;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_register_defaults();
    test_unit_encodings();
    test_field_limits();
    test_random_stream();
    wait_utf8_drain();
    if (fault_count == 0) begin
      $display("length_prefixed_utf16be_to_utf8 regression: pass");
    end else begin
      $display("length_prefixed_utf16be_to_utf8 regression: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("length_prefixed_utf16be_to_utf8 regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lu2u_pkg.sv
hdl/lu2u_front.sv
hdl/lu2u_fifo.sv
hdl/lu2u_back.sv
hdl/length_prefixed_utf16be_to_utf8.sv
bench/tb.sv
